// File: hdl/assert_macros.svh
// Assertion macros shared by the S19 encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SRE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sre assertion failed");
// Antecedent implies consequent in the same cycle.
`define SRE_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sre assertion failed");
`else
`define SRE_ASSERT_ALWAYS(lbl, prop)
`define SRE_ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

// File: hdl/sre_pkg.sv
// Shared types, constants and helper functions of the S19 text encoder.
package sre_pkg;

  localparam int BPR_DEFAULT   = 16;
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int HDR_MAX       = 8;
  localparam int FILL_W        = 5;
  localparam int LEN_W         = 5;

  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_NL = 8'h0A;

  // Config register indexes
  localparam logic CFG_HEADER_TEXT   = 1'b0;
  localparam logic CFG_HEADER_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    REC_S0,
    REC_S1,
    REC_S5,
    REC_S9
  } rec_kind_t;

  // One record request from front to back
  typedef struct packed {
    rec_kind_t        kind;
    logic [15:0]      addr;
    logic [LEN_W-1:0] len;
    logic             bank;
    logic             last;
  } rec_cmd_t;

  // Buffer bank handed back once its S1 record is out
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_HDR,
    F_DATA,
    F_END_S1,
    F_END_S5,
    F_END_S9
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_S,
    B_TYPE,
    B_HEX,
    B_NL
  } back_state_t;

  // Uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

  // Record type digit
  function automatic logic [7:0] type_char(input rec_kind_t k);
    logic [7:0] r;
    unique case (k)
      REC_S0:  r = 8'h30;
      REC_S1:  r = 8'h31;
      REC_S5:  r = 8'h35;
      REC_S9:  r = 8'h39;
      default: r = 8'h30;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/sre_cmd_fifo.sv
// Short record request queue between the front and the back.
`include "assert_macros.svh"
module sre_cmd_fifo
  import sre_pkg::*;
#(
  parameter int DEPTH = CMD_FIFO_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rec_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output rec_cmd_t head,
  output logic     head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rec_cmd_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SRE_ASSERT_IMPLIES(a_no_overflow, push, !full)
  `SRE_ASSERT_IMPLIES(a_no_underflow, pop, head_valid)

endmodule

// File: hdl/sre_front.sv
// Front end: accepts items, fills the byte buffer and queues record requests.
module sre_front
  import sre_pkg::*;
#(
  parameter int BPR = BPR_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] func
  input  logic [3:0] header_length,
  output logic       cmd_push,
  output rec_cmd_t   cmd,
  input  logic       cmd_full,
  input  bank_rel_t  rel,
  input  logic       rd_bank,
  input  logic [4:0] rd_idx,
  output logic [7:0] rd_data
);

  localparam int BIDX_W = (BPR > 1) ? $clog2(BPR) : 1;
  localparam logic [FILL_W-1:0] FULL_AT = FILL_W'(BPR - 1);
  localparam logic [LEN_W-1:0]  BPR_LEN = LEN_W'(BPR);

  front_state_t state, state_next;

  logic              item_func;
  logic [7:0]        item_byte;
  logic              header_done;
  logic [FILL_W-1:0] fill_count;
  logic [15:0]       next_address;
  logic [15:0]       s1_count;
  logic              wbank;
  logic [1:0]        bank_busy;
  logic [7:0]        buffer [2][BPR];

  logic             accept;
  logic             full_now;
  logic             data_go;
  logic [LEN_W-1:0] hdr_len;
  logic [1:0]       busy_set;

  assign accept   = s_tvalid && s_tready;
  assign full_now = (fill_count == FULL_AT);
  assign data_go  = !bank_busy[wbank] && (!full_now || !cmd_full);
  assign hdr_len  = (header_length > 4'(HDR_MAX)) ? LEN_W'(HDR_MAX)
                                                  : LEN_W'(header_length);
  assign rd_data  = buffer[rd_bank][rd_idx[BIDX_W-1:0]];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) state_next = header_done ? F_DATA : F_HDR;
      end
      F_HDR: begin
        if (!cmd_full) state_next = F_DATA;
      end
      F_DATA: begin
        if (item_func) begin
          state_next = (fill_count != '0) ? F_END_S1 : F_END_S5;
        end else if (data_go) begin
          state_next = F_IDLE;
        end
      end
      F_END_S1: begin
        if (!cmd_full) state_next = F_END_S5;
      end
      F_END_S5: begin
        if (!cmd_full) state_next = F_END_S9;
      end
      F_END_S9: begin
        if (!cmd_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Outputs: handshake and record requests
  always_comb begin
    s_tready  = 1'b0;
    cmd_push  = 1'b0;
    cmd       = '{kind: REC_S0, addr: 16'h0000, len: '0, bank: wbank, last: 1'b0};
    busy_set  = 2'b00;
    unique case (state)
      F_IDLE: s_tready = 1'b1;
      F_HDR: begin
        cmd_push = !cmd_full;
        cmd.kind = REC_S0;
        cmd.len  = hdr_len;
        cmd.last = !item_func && !full_now;
      end
      F_DATA: begin
        if (!item_func && data_go && full_now) begin
          cmd_push        = 1'b1;
          cmd.kind        = REC_S1;
          cmd.addr        = next_address;
          cmd.len         = BPR_LEN;
          cmd.last        = 1'b1;
          busy_set[wbank] = 1'b1;
        end
      end
      F_END_S1: begin
        cmd_push        = !cmd_full;
        cmd.kind        = REC_S1;
        cmd.addr        = next_address;
        cmd.len         = LEN_W'(fill_count);
        busy_set[wbank] = !cmd_full;
      end
      F_END_S5: begin
        cmd_push = !cmd_full;
        cmd.kind = REC_S5;
        cmd.addr = s1_count;
      end
      F_END_S9: begin
        cmd_push = !cmd_full;
        cmd.kind = REC_S9;
        cmd.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Buffer writes
  always_ff @(posedge clk) begin
    if (state == F_DATA && !item_func && data_go) begin
      buffer[wbank][fill_count[BIDX_W-1:0]] <= item_byte;
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      item_func <= s_tuser;
      item_byte <= s_tdata;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      header_done  <= 1'b0;
      fill_count   <= '0;
      next_address <= '0;
      s1_count     <= '0;
      wbank        <= 1'b0;
      bank_busy    <= 2'b00;
    end else begin
      state <= state_next;
      bank_busy <= (bank_busy & ~({1'b0, rel.valid} << rel.bank)) | busy_set;
      case (state)
        F_HDR: begin
          if (!cmd_full) header_done <= 1'b1;
        end
        F_DATA: begin
          if (!item_func && data_go) begin
            if (full_now) begin
              fill_count   <= '0;
              next_address <= next_address + 16'(BPR);
              s1_count     <= s1_count + 16'd1;
              wbank        <= ~wbank;
            end else begin
              fill_count <= fill_count + 1'b1;
            end
          end
        end
        F_END_S1: begin
          if (!cmd_full) begin
            next_address <= next_address + 16'(fill_count);
            s1_count     <= s1_count + 16'd1;
            fill_count   <= '0;
            wbank        <= ~wbank;
          end
        end
        F_END_S9: begin
          if (!cmd_full) begin
            header_done  <= 1'b0;
            fill_count   <= '0;
            next_address <= '0;
            s1_count     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/sre_back.sv
// Back end: turns record requests into S19 characters, one per cycle within a record while m_tready is high.
`include "assert_macros.svh"
module sre_back
  import sre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rec_cmd_t    cmd,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  input  logic [63:0] header_text,
  output logic        rd_bank,
  output logic [4:0]  rd_idx,
  input  logic [7:0]  rd_data,
  output bank_rel_t   rel,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] text_char
  output logic        m_tuser,   // [0] line_end
  output logic        m_tlast    // last character of a request flagged last
);

  back_state_t state, state_next;

  rec_cmd_t   cur;
  logic [4:0] pos;
  logic       nib;
  logic [7:0] sum;

  logic       slot_free;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_end;
  logic       emit_last;
  logic [4:0] sum_pos;
  logic [4:0] data_idx;
  logic [7:0] cur_byte;

  assign slot_free = !m_tvalid || m_tready;
  assign sum_pos   = cur.len + 5'd3;
  assign data_idx  = pos - 5'd3;
  assign rd_bank   = cur.bank;
  assign rd_idx    = data_idx;

  // Byte at the current position of the record
  always_comb begin
    if (pos == 5'd0) begin
      cur_byte = {3'b000, cur.len} + 8'd3;
    end else if (pos == 5'd1) begin
      cur_byte = cur.addr[15:8];
    end else if (pos == 5'd2) begin
      cur_byte = cur.addr[7:0];
    end else if (pos == sum_pos) begin
      cur_byte = ~sum;
    end else if (cur.kind == REC_S0) begin
      cur_byte = header_text[{data_idx[2:0], 3'b000} +: 8];
    end else begin
      cur_byte = rd_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (cmd_valid) state_next = B_S;
      B_S:    if (slot_free) state_next = B_TYPE;
      B_TYPE: if (slot_free) state_next = B_HEX;
      B_HEX:  if (slot_free && nib && pos == sum_pos) state_next = B_NL;
      B_NL:   if (slot_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs: character to emit, queue pop, bank release
  always_comb begin
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    emit_char = CHAR_S;
    emit_end  = 1'b0;
    emit_last = 1'b0;
    rel       = '{valid: 1'b0, bank: cur.bank};
    unique case (state)
      B_IDLE: cmd_pop = cmd_valid;
      B_S: begin
        emit = slot_free;
      end
      B_TYPE: begin
        emit      = slot_free;
        emit_char = type_char(cur.kind);
      end
      B_HEX: begin
        emit      = slot_free;
        emit_char = hex_char(nib ? cur_byte[3:0] : cur_byte[7:4]);
      end
      B_NL: begin
        emit      = slot_free;
        emit_char = CHAR_NL;
        emit_end  = 1'b1;
        emit_last = cur.last;
        rel.valid = slot_free && (cur.kind == REC_S1);
      end
      default: ;
    endcase
  end

  // Record walk
  always_ff @(posedge clk) begin
    if (state == B_IDLE && cmd_valid) begin
      cur <= cmd;
      pos <= '0;
      nib <= 1'b0;
      sum <= '0;
    end else if (state == B_HEX && slot_free) begin
      nib <= ~nib;
      if (nib) begin
        pos <= pos + 5'd1;
        sum <= sum + cur_byte;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_char;
      m_tuser <= emit_end;
      m_tlast <= emit_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `SRE_ASSERT_IMPLIES(a_line_end_is_nl, m_tvalid && m_tuser, m_tdata == CHAR_NL)
  `SRE_ASSERT_IMPLIES(a_last_on_line_end, m_tvalid && m_tlast, m_tuser)
  `SRE_ASSERT_ALWAYS(a_pos_in_record, !(state == B_HEX && pos > sum_pos))

endmodule

// File: hdl/srecord_s19_text_encoder_unit.sv
// A record's first character is registered once the back end takes its request from
// the queue. Throughput: one character per cycle within a record while m_tready is high,
// set by the back end's character sequencer; a record of N bytes is 2N+11 characters.
// The front takes no new item until done with the last; front and back are decoupled
// by a two-entry request queue and a double-banked byte buffer.
// Reset (rst, synchronous): clears all control state and the config registers.
module srecord_s19_text_encoder_unit
  import sre_pkg::*;
#(
  parameter int BYTES_PER_RECORD = BPR_DEFAULT,
  parameter int CMD_DEPTH        = CMD_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] text_char
  output logic        m_tuser,   // [0] line_end
  output logic        m_tlast,   // last
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] header_text;
  logic [3:0]  header_length;

  logic       cmd_push;
  rec_cmd_t   push_cmd;
  logic       cmd_full;
  logic       cmd_pop;
  rec_cmd_t   head;
  logic       head_valid;
  bank_rel_t  rel;
  logic       rd_bank;
  logic [4:0] rd_idx;
  logic [7:0] rd_data;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_text   <= '0;
      header_length <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HEADER_TEXT:   header_text   <= cfg_wdata;
        CFG_HEADER_LENGTH: header_length <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  sre_front #(
    .BPR(BYTES_PER_RECORD)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .header_length (header_length),
    .cmd_push      (cmd_push),
    .cmd           (push_cmd),
    .cmd_full      (cmd_full),
    .rel           (rel),
    .rd_bank       (rd_bank),
    .rd_idx        (rd_idx),
    .rd_data       (rd_data)
  );

  sre_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (push_cmd),
    .full       (cmd_full),
    .pop        (cmd_pop),
    .head       (head),
    .head_valid (head_valid)
  );

  sre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (head),
    .cmd_valid   (head_valid),
    .cmd_pop     (cmd_pop),
    .header_text (header_text),
    .rd_bank     (rd_bank),
    .rd_idx      (rd_idx),
    .rd_data     (rd_data),
    .rel         (rel),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule
